/* rtl/wsd_pkg.sv */
// shared types and constants for the websocket frame deframer
package wsd_pkg;

	// result kind codes
	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_EMPTY  = 2'd1,
		KIND_NOMASK = 2'd2,
		KIND_BADLEN = 2'd3
	} kind_t;

	// header length code thresholds
	localparam logic [6:0]  LEN_CODE_MAX_SHORT = 7'd125;
	localparam logic [6:0]  LEN_CODE_EXT16     = 7'd126;
	localparam logic [63:0] LEN_EXT16_MIN      = 64'd126;

	// one classified word waiting for the back end
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] key;
		logic       last;
		logic       fin;
		logic [2:0] rsv;
		logic [3:0] opcode;
	} wsd_entry_t;

endpackage

/* rtl/websocket_frame_deframer.sv */
// an accepted word is written into the queue, then loaded into the output register
// throughput: one word per cycle while the queue has room, set by the single-pass front parser
// a full four-entry queue stalls the input until the output side drains
// reset: async active low, parser back to first header byte, queue empty
// results: payload words, empty frame end, missing mask and bad length
// top level of the websocket client frame deframer
module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// input byte stream
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	// result stream
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic       last_of_frame,
	output logic       fin_flag,
	output logic [2:0] reserved_bits,
	output logic [3:0] frame_opcode
);
	import wsd_pkg::*;

	logic       accept;
	logic       push;
	wsd_entry_t push_entry;
	wsd_entry_t pop_entry;
	logic       pop;
	logic       q_full;
	logic       q_not_empty;
	kind_t      kind_int;

	// input word taken whenever the queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// parser: classifies every word, pushes only those that make a result
	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples parser from the output side
	wsd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.not_empty  (q_not_empty)
	);

	// unmask and present results
	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_entry   (pop_entry),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind_o    (kind_int),
		.payload_o (payload_byte),
		.last_o    (last_of_frame),
		.fin_o     (fin_flag),
		.rsv_o     (reserved_bits),
		.opcode_o  (frame_opcode)
	);

	assign kind = kind_int;

`ifndef SYNTHESIS
	// parser never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) !(push && q_full))
		else $error("push into full queue");

	// back end never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && !q_not_empty))
		else $error("pop from empty queue");

	// non-payload results carry zero data and close the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind_int != KIND_DATA) |-> (payload_byte == 8'd0 && last_of_frame))
		else $error("non-payload result malformed");

	// a word pushed while queue and output side are empty is queued, then shown in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_not_empty && !out_valid) |=> ##1 out_valid)
		else $error("result not presented");
`endif

endmodule

/* rtl/wsd_front.sv */
// front end: header, length and mask key parsing, classifies each word
module wsd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	output logic                push,
	output wsd_pkg::wsd_entry_t push_entry
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_MASK  = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	phase_t      phase_q;
	logic        fin_q;
	logic [2:0]  rsv_q;
	logic [3:0]  opcode_q;
	logic [2:0]  field_cnt_q;
	logic [63:0] len_acc_q;
	logic [31:0] mask_key_q;
	logic [62:0] remaining_q;
	logic [1:0]  mask_off_q;

	logic [63:0] len_acc_next;
	logic        ext16_bad;
	logic        ext64_bad;
	logic [7:0]  key_byte;
	logic        data_last;

	assign len_acc_next = {len_acc_q[55:0], data_byte};
	assign ext16_bad    = len_acc_next < LEN_EXT16_MIN;
	assign ext64_bad    = (len_acc_next[63:16] == 48'd0) || len_acc_next[63];
	assign data_last    = remaining_q == 63'd1;

	// mask key byte for this payload offset, big-endian key order
	always_comb begin
		case (mask_off_q)
			2'd0:    key_byte = mask_key_q[31:24];
			2'd1:    key_byte = mask_key_q[23:16];
			2'd2:    key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
	end

	// classify the word, decide whether it makes a result
	always_comb begin
		push              = 1'b0;
		push_entry.kind   = KIND_DATA;
		push_entry.data   = data_byte;
		push_entry.key    = key_byte;
		push_entry.last   = 1'b1;
		push_entry.fin    = fin_q;
		push_entry.rsv    = rsv_q;
		push_entry.opcode = opcode_q;
		unique case (phase_q)
			PH_HDR1: begin
				if (!data_byte[7]) begin
					push            = accept;
					push_entry.kind = KIND_NOMASK;
				end
			end
			PH_EXT16: begin
				if (field_cnt_q >= 3'd1 && ext16_bad) begin
					push            = accept;
					push_entry.kind = KIND_BADLEN;
				end
			end
			PH_EXT64: begin
				if (field_cnt_q >= 3'd7 && ext64_bad) begin
					push            = accept;
					push_entry.kind = KIND_BADLEN;
				end
			end
			PH_MASK: begin
				if (field_cnt_q >= 3'd3 && remaining_q == 63'd0) begin
					push            = accept;
					push_entry.kind = KIND_EMPTY;
				end
			end
			PH_DATA: begin
				push            = accept;
				push_entry.last = data_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			fin_q       <= 1'b0;
			rsv_q       <= 3'd0;
			opcode_q    <= 4'd0;
			field_cnt_q <= 3'd0;
			len_acc_q   <= 64'd0;
			mask_key_q  <= 32'd0;
			remaining_q <= 63'd0;
			mask_off_q  <= 2'd0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HDR1: begin
					if (!data_byte[7]) begin
						phase_q <= PH_HDR0;
					end else begin
						field_cnt_q <= 3'd0;
						len_acc_q   <= 64'd0;
						if (data_byte[6:0] <= LEN_CODE_MAX_SHORT) begin
							remaining_q <= {56'd0, data_byte[6:0]};
							mask_key_q  <= 32'd0;
							phase_q     <= PH_MASK;
						end else if (data_byte[6:0] == LEN_CODE_EXT16) begin
							phase_q <= PH_EXT16;
						end else begin
							phase_q <= PH_EXT64;
						end
					end
				end
				PH_EXT16: begin
					len_acc_q <= len_acc_next;
					if (field_cnt_q >= 3'd1) begin
						if (ext16_bad) begin
							phase_q <= PH_HDR0;
						end else begin
							remaining_q <= len_acc_next[62:0];
							field_cnt_q <= 3'd0;
							mask_key_q  <= 32'd0;
							phase_q     <= PH_MASK;
						end
					end else begin
						field_cnt_q <= field_cnt_q + 3'd1;
					end
				end
				PH_EXT64: begin
					len_acc_q <= len_acc_next;
					if (field_cnt_q >= 3'd7) begin
						if (ext64_bad) begin
							phase_q <= PH_HDR0;
						end else begin
							remaining_q <= len_acc_next[62:0];
							field_cnt_q <= 3'd0;
							mask_key_q  <= 32'd0;
							phase_q     <= PH_MASK;
						end
					end else begin
						field_cnt_q <= field_cnt_q + 3'd1;
					end
				end
				PH_MASK: begin
					mask_key_q <= {mask_key_q[23:0], data_byte};
					if (field_cnt_q >= 3'd3) begin
						field_cnt_q <= 3'd0;
						mask_off_q  <= 2'd0;
						phase_q     <= (remaining_q == 63'd0) ? PH_HDR0 : PH_DATA;
					end else begin
						field_cnt_q <= field_cnt_q + 3'd1;
					end
				end
				PH_DATA: begin
					mask_off_q  <= mask_off_q + 2'd1;
					remaining_q <= remaining_q - 63'd1;
					if (data_last) begin
						phase_q <= PH_HDR0;
					end
				end
				default: begin
					fin_q    <= data_byte[7];
					rsv_q    <= data_byte[6:4];
					opcode_q <= data_byte[3:0];
					phase_q  <= PH_HDR1;
				end
			endcase
		end
	end

endmodule

/* rtl/wsd_fifo.sv */
// short queue between front and back ends
module wsd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wsd_pkg::wsd_entry_t push_entry,
	input  logic                pop,
	output wsd_pkg::wsd_entry_t pop_entry,
	output logic                full,
	output logic                not_empty
);
	import wsd_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	wsd_entry_t    slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/wsd_back.sv */
// back end: unmasks payload words and holds the output register
module wsd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  wsd_pkg::wsd_entry_t q_entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output wsd_pkg::kind_t      kind_o,
	output logic [7:0]          payload_o,
	output logic                last_o,
	output logic                fin_o,
	output logic [2:0]          rsv_o,
	output logic [3:0]          opcode_o
);
	import wsd_pkg::*;

	logic load;

	// output register free or being taken this cycle
	assign load = !out_valid || !out_stall;
	assign pop  = load && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_o    <= q_entry.kind;
			payload_o <= (q_entry.kind == KIND_DATA) ? (q_entry.data ^ q_entry.key) : 8'd0;
			last_o    <= q_entry.last;
			fin_o     <= q_entry.fin;
			rsv_o     <= q_entry.rsv;
			opcode_o  <= q_entry.opcode;
		end
	end

endmodule
